// ----- hw/rtl/prd_pkg.sv -----
`timescale 1ns / 1ps

package prd_pkg;

  localparam int COORD_W  = 16;
  localparam int REG_W    = 24;
  localparam int ROW_W    = 48;
  localparam int ENTRY_W  = 16;
  localparam int DIR_W    = 16;
  localparam int CFG_IDX_W = 3;

  localparam int MAG_W    = 46;
  localparam int SMAG_W   = 30;
  localparam int SHIFT_W  = 5;
  localparam int SUM_W    = 62;
  localparam int ROOT_W   = 31;
  localparam int QUO_W    = 29;
  localparam int DVD_W    = SMAG_W + QUO_W - 1;
  localparam int SQRT_N   = 31;
  localparam int CAM_FRAC = 28;
  localparam int DIR_FRAC = 14;

  typedef logic [MAG_W-1:0] mag_t;
  typedef logic [QUO_W-1:0] quo_t;

  typedef struct packed {
    logic       zero;
    logic [2:0] neg;
  } norm_side_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INV_WIDTH,
    CFG_INV_HEIGHT,
    CFG_ASPECT,
    CFG_HALF_FOV_TAN,
    CFG_LEFT_HANDED,
    CFG_ROT_ROW_0,
    CFG_ROT_ROW_1,
    CFG_ROT_ROW_2
  } cfg_idx_e;

endpackage

// ----- hw/rtl/perspective_ray_direction.sv -----
`timescale 1ns / 1ps
// Channel  Direction  Word                                         Side info
// s_axis   in         tdata: coord_x, coord_y                      tuser: kind
// m_axis   out        tdata: dir_x, dir_y, dir_z                   tuser: zero_length
// cfg      in         cfg_index_i selects register, cfg_data_i     always ready
//
// One word enters per cycle unless the output stalls. Two normalize units of
// 65 stages each (31 square-root and 29 divide steps per unit) form the pipeline.
// Reset clears valid bits and configuration registers; payload stages are not reset.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.

module perspective_ray_direction (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [2*prd_pkg::COORD_W-1:0]  s_axis_tdata,  // coord_x, coord_y
  input  logic [0:0]                     s_axis_tuser,  // kind
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [3*prd_pkg::DIR_W-1:0]    m_axis_tdata,  // dir_x, dir_y, dir_z
  output logic [0:0]                     m_axis_tuser,  // zero_length
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [prd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [prd_pkg::ROW_W-1:0]      cfg_data_i
);
  import prd_pkg::*;

  localparam int N_W = 25;
  localparam logic [N_W-1:0] ONE_Q24 = N_W'(1) << 24;

  logic [REG_W-1:0] inv_w_q, inv_h_q, aspect_q, tan_q;
  logic             left_q;
  logic [ROW_W-1:0] rot_q [3];

  logic en;

  logic             s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q;
  logic [N_W-1:0]   nx_q, ny_q;
  logic [N_W-1:0]   tx_q, ty_q;
  logic             xneg2_q, yneg2_q, xneg3_q, yneg3_q;
  logic [32:0]      ax_q, cy3_q;
  mag_t             cam_q [3];
  norm_side_t       cam_side_q;
  logic [N_W-1:0]   nx_d, ny_d;
  logic [N_W:0]     two_nx, two_ny;
  logic [48:0]      ax_full, cy_full;
  logic [56:0]      cx_full;

  logic             n1_vld;
  quo_t             n1_quo [3];
  norm_side_t       n1_side;

  logic signed [SMAG_W-1:0] unit_s [3];
  logic signed [45:0] prod_q [3][3];
  logic signed [47:0] world_q [3];
  logic             s5_vld_q, s6_vld_q, s7_vld_q;
  mag_t             wmag_q [3];
  norm_side_t       wside_q;

  logic             n2_vld;
  quo_t             n2_quo [3];
  norm_side_t       n2_side;

  logic             out_vld_q;
  logic [DIR_W-1:0] dir_q [3];
  logic             zero_q;

  function automatic logic [N_W-1:0] unit_coord(input logic kind,
                                                input logic [COORD_W-1:0] coord,
                                                input logic [REG_W-1:0] inv);
    logic [COORD_W+REG_W-1:0] prod;
    logic [COORD_W-1:0]       clamped;
    logic [N_W-1:0]           res;
    prod = coord * inv;
    clamped = (coord > COORD_W'(32768)) ? COORD_W'(32768) : coord;
    if (kind) begin
      res = {clamped, 9'b0};
    end else if (prod[COORD_W+REG_W-1:4] > (COORD_W+REG_W-4)'(ONE_Q24)) begin
      res = ONE_Q24;
    end else begin
      res = prod[N_W+3:4];
    end
    return res;
  endfunction

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_w_q  <= '0;
      inv_h_q  <= '0;
      aspect_q <= REG_W'(65536);
      tan_q    <= REG_W'(65536);
      left_q   <= 1'b0;
      rot_q[0] <= '0;
      rot_q[1] <= '0;
      rot_q[2] <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_INV_WIDTH:    inv_w_q  <= cfg_data_i[REG_W-1:0];
        CFG_INV_HEIGHT:   inv_h_q  <= cfg_data_i[REG_W-1:0];
        CFG_ASPECT:       aspect_q <= cfg_data_i[REG_W-1:0];
        CFG_HALF_FOV_TAN: tan_q    <= cfg_data_i[REG_W-1:0];
        CFG_LEFT_HANDED:  left_q   <= cfg_data_i[0];
        CFG_ROT_ROW_0:    rot_q[0] <= cfg_data_i;
        CFG_ROT_ROW_1:    rot_q[1] <= cfg_data_i;
        CFG_ROT_ROW_2:    rot_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  assign nx_d    = unit_coord(s_axis_tuser[0], s_axis_tdata[COORD_W-1:0], inv_w_q);
  assign ny_d    = unit_coord(s_axis_tuser[0], s_axis_tdata[2*COORD_W-1:COORD_W], inv_h_q);
  assign two_nx  = {nx_q, 1'b0};
  assign two_ny  = {ny_q, 1'b0};
  assign ax_full = tx_q * aspect_q;
  assign cy_full = ty_q * tan_q;
  assign cx_full = ax_q * tan_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      s6_vld_q  <= 1'b0;
      s7_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q  <= s_axis_tvalid;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= s3_vld_q;
      s5_vld_q  <= n1_vld;
      s6_vld_q  <= s5_vld_q;
      s7_vld_q  <= s6_vld_q;
      out_vld_q <= n2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_q <= nx_d;
      ny_q <= ny_d;

      xneg2_q <= two_nx < (N_W+1)'(ONE_Q24);
      yneg2_q <= two_ny > (N_W+1)'(ONE_Q24);
      tx_q    <= (two_nx < (N_W+1)'(ONE_Q24)) ? N_W'((N_W+1)'(ONE_Q24) - two_nx)
                                               : N_W'(two_nx - (N_W+1)'(ONE_Q24));
      ty_q    <= (two_ny > (N_W+1)'(ONE_Q24)) ? N_W'(two_ny - (N_W+1)'(ONE_Q24))
                                               : N_W'((N_W+1)'(ONE_Q24) - two_ny);

      xneg3_q <= xneg2_q;
      yneg3_q <= yneg2_q;
      ax_q    <= ax_full[48:16];
      cy3_q   <= cy_full[48:16];

      cam_q[0]        <= MAG_W'(cx_full[56:16]);
      cam_q[1]        <= MAG_W'(cy3_q);
      cam_q[2]        <= MAG_W'(ONE_Q24);
      cam_side_q.zero <= 1'b0;
      cam_side_q.neg  <= {!left_q, yneg3_q, xneg3_q};
    end
  end

  prd_norm u_cam_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .round_i (1'b0),
    .valid_i (s4_vld_q),
    .mag_i   (cam_q),
    .side_i  (cam_side_q),
    .valid_o (n1_vld),
    .quo_o   (n1_quo),
    .side_o  (n1_side)
  );

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      unit_s[j] = n1_side.neg[j] ? -$signed({1'b0, n1_quo[j]}) : $signed({1'b0, n1_quo[j]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_q[i][j] <= $signed(rot_q[i][ENTRY_W*j +: ENTRY_W]) * unit_s[j];
        end
        world_q[i] <= {{2{prod_q[i][0][45]}}, prod_q[i][0]}
                    + {{2{prod_q[i][1][45]}}, prod_q[i][1]}
                    + {{2{prod_q[i][2][45]}}, prod_q[i][2]};
        wmag_q[i]  <= world_q[i][47] ? MAG_W'(-world_q[i]) : MAG_W'(world_q[i]);
        wside_q.neg[i] <= world_q[i][47];
      end
      wside_q.zero <= (world_q[0] == '0) && (world_q[1] == '0) && (world_q[2] == '0);
    end
  end

  prd_norm u_world_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .round_i (1'b1),
    .valid_i (s7_vld_q),
    .mag_i   (wmag_q),
    .side_i  (wside_q),
    .valid_o (n2_vld),
    .quo_o   (n2_quo),
    .side_o  (n2_side)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        if (n2_side.zero) begin
          dir_q[j] <= '0;
        end else if (n2_side.neg[j]) begin
          dir_q[j] <= -n2_quo[j][DIR_W-1:0];
        end else begin
          dir_q[j] <= n2_quo[j][DIR_W-1:0];
        end
      end
      zero_q <= n2_side.zero;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {dir_q[2], dir_q[1], dir_q[0]};
  assign m_axis_tuser  = zero_q;

endmodule

// ----- hw/rtl/prd_norm.sv -----
`timescale 1ns / 1ps

module prd_norm (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                round_i,
  input  logic                valid_i,
  input  prd_pkg::mag_t       mag_i [3],
  input  prd_pkg::norm_side_t side_i,
  output logic                valid_o,
  output prd_pkg::quo_t       quo_o [3],
  output prd_pkg::norm_side_t side_o
);
  import prd_pkg::*;

  logic             a_vld_q, b_vld_q, c_vld_q;
  mag_t             a_mag_q [3];
  mag_t             a_max_q;
  norm_side_t       a_side_q, b_side_q, c_side_q;
  logic [SMAG_W-1:0] b_mag_q [3];
  logic [SMAG_W-1:0] c_mag_q [3];
  logic [2*SMAG_W-1:0] c_sq_q [3];
  mag_t             max_d;
  logic [SHIFT_W-1:0] shift_d;

  logic              sq_vld_q  [0:SQRT_N];
  logic [SUM_W-1:0]  sq_v_q    [0:SQRT_N];
  logic [SUM_W-1:0]  sq_res_q  [0:SQRT_N];
  logic [SMAG_W-1:0] sq_mag_q  [0:SQRT_N][3];
  norm_side_t        sq_side_q [0:SQRT_N];

  logic              dv_vld_q  [0:QUO_W];
  logic [ROOT_W-1:0] dv_len_q  [0:QUO_W];
  logic [ROOT_W-1:0] dv_rem_q  [0:QUO_W][3];
  logic [QUO_W-1:0]  dv_sh_q   [0:QUO_W][3];
  norm_side_t        dv_side_q [0:QUO_W];

  logic [ROOT_W-1:0] len_d;
  logic [DVD_W-1:0]  dvd_d [3];

  always_comb begin
    max_d = mag_i[0];
    if (mag_i[1] > max_d) begin
      max_d = mag_i[1];
    end
    if (mag_i[2] > max_d) begin
      max_d = mag_i[2];
    end
  end

  always_comb begin
    shift_d = '0;
    for (int k = 0; k < MAG_W - SMAG_W; k++) begin
      if (a_max_q[SMAG_W+k]) begin
        shift_d = SHIFT_W'(k + 1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q     <= 1'b0;
      b_vld_q     <= 1'b0;
      c_vld_q     <= 1'b0;
      sq_vld_q[0] <= 1'b0;
      dv_vld_q[0] <= 1'b0;
    end else if (en_i) begin
      a_vld_q     <= valid_i;
      b_vld_q     <= a_vld_q;
      c_vld_q     <= b_vld_q;
      sq_vld_q[0] <= c_vld_q;
      dv_vld_q[0] <= sq_vld_q[SQRT_N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_mag_q  <= mag_i;
      a_max_q  <= max_d;
      a_side_q <= side_i;
      b_side_q <= a_side_q;
      c_side_q <= b_side_q;
      for (int j = 0; j < 3; j++) begin
        b_mag_q[j] <= SMAG_W'(a_mag_q[j] >> shift_d);
        c_mag_q[j] <= b_mag_q[j];
        c_sq_q[j]  <= b_mag_q[j] * b_mag_q[j];
      end
      sq_v_q[0]    <= SUM_W'(c_sq_q[0]) + SUM_W'(c_sq_q[1]) + SUM_W'(c_sq_q[2]);
      sq_res_q[0]  <= '0;
      sq_mag_q[0]  <= c_mag_q;
      sq_side_q[0] <= c_side_q;
    end
  end

  for (genvar k = 0; k < SQRT_N; k++) begin : g_sqrt
    localparam logic [SUM_W:0] BIT = {{SUM_W{1'b0}}, 1'b1} << (SUM_W - 2 - 2 * k);
    logic [SUM_W:0] trial;
    assign trial = {1'b0, sq_res_q[k]} + BIT;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        sq_vld_q[k+1] <= sq_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if ({1'b0, sq_v_q[k]} >= trial) begin
          sq_v_q[k+1]   <= sq_v_q[k] - trial[SUM_W-1:0];
          sq_res_q[k+1] <= (sq_res_q[k] >> 1) + BIT[SUM_W-1:0];
        end else begin
          sq_v_q[k+1]   <= sq_v_q[k];
          sq_res_q[k+1] <= sq_res_q[k] >> 1;
        end
        sq_mag_q[k+1]  <= sq_mag_q[k];
        sq_side_q[k+1] <= sq_side_q[k];
      end
    end
  end

  assign len_d = sq_res_q[SQRT_N][ROOT_W-1:0];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (round_i) begin
        dvd_d[j] = DVD_W'({sq_mag_q[SQRT_N][j], {DIR_FRAC{1'b0}}})
                 + DVD_W'(len_d >> 1);
      end else begin
        dvd_d[j] = {sq_mag_q[SQRT_N][j], {CAM_FRAC{1'b0}}};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dv_len_q[0]  <= len_d;
      dv_side_q[0] <= sq_side_q[SQRT_N];
      for (int j = 0; j < 3; j++) begin
        dv_rem_q[0][j] <= ROOT_W'(dvd_d[j][DVD_W-1:QUO_W]);
        dv_sh_q[0][j]  <= dvd_d[j][QUO_W-1:0];
      end
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        dv_vld_q[k+1] <= dv_vld_q[k];
      end
    end

    for (genvar j = 0; j < 3; j++) begin : g_lane
      logic [ROOT_W:0] trial;
      logic            ge;
      assign trial = {dv_rem_q[k][j], dv_sh_q[k][j][QUO_W-1]};
      assign ge    = trial >= {1'b0, dv_len_q[k]};

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          dv_rem_q[k+1][j] <= ge ? ROOT_W'(trial - {1'b0, dv_len_q[k]})
                                 : ROOT_W'(trial);
          dv_sh_q[k+1][j]  <= {dv_sh_q[k][j][QUO_W-2:0], ge};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_len_q[k+1]  <= dv_len_q[k];
        dv_side_q[k+1] <= dv_side_q[k];
      end
    end
  end

  assign valid_o = dv_vld_q[QUO_W];
  assign side_o  = dv_side_q[QUO_W];
  assign quo_o   = dv_sh_q[QUO_W];

endmodule
